FILE: hw/rtl/mrhm_pkg.sv
// Shared types, codes and constants of the Modbus RTU read-holding master.
// Depends on nothing; imported by mrhm_front, mrhm_queue, mrhm_back and the top level.
package mrhm_pkg;

  localparam int REPLY_BUFFER_BYTES = 64;
  localparam int STORE_DEPTH        = 29;
  localparam int WORD_IDX_W         = 5;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [6:0]  REPLY_OVERHEAD    = 7'd5;

  localparam logic [7:0]  RST_SLAVE_ID       = 8'd1;
  localparam logic [15:0] RST_START_REGISTER = 16'd0;
  localparam logic [4:0]  RST_REGISTER_COUNT = 5'd8;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd1000;

  typedef enum logic [1:0] {
    REG_SLAVE_ID       = 2'd0,
    REG_START_REGISTER = 2'd1,
    REG_REGISTER_COUNT = 2'd2,
    REG_TIMEOUT_TICKS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_WORD    = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_CRC_BAD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_STATUS  = 2'd1,
    CMD_WORDS   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [7:0]            slave;
    logic [15:0]           start;
    logic [WORD_IDX_W-1:0] count;
    logic                  oversize;
    status_t               code;
  } cmd_t;

  typedef struct packed {
    logic burst_done;
  } back_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mrhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mrhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mrhm_front.sv
// Front part: configuration registers, input acceptance, reply parsing,
// running CRC, timeout and word store writes. Depends on mrhm_pkg.
module mrhm_front import mrhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  logic                  q_full,
  input  back_stat_t            back_stat,
  output logic                  ram_we,
  output logic [WORD_IDX_W-1:0] ram_waddr,
  output logic [15:0]           ram_wdata
);

  logic [7:0]            cfg_slave;
  logic [15:0]           cfg_start;
  logic [WORD_IDX_W-1:0] cfg_count;
  logic [15:0]           cfg_timeout;

  logic                  awaiting, awaiting_next;
  logic [6:0]            bytes_received, bytes_received_next;
  logic [15:0]           elapsed, elapsed_next;
  logic [15:0]           running_crc, running_crc_next;
  logic                  header_bad, header_bad_next;
  logic [7:0]            held_high, held_high_next;
  logic [7:0]            crc_low, crc_low_next;
  logic [7:0]            run_slave, run_slave_next;
  logic [WORD_IDX_W-1:0] run_count, run_count_next;
  logic                  burst_pending, burst_pending_next;

  logic                  accept;
  logic                  oversize;
  logic [6:0]            total;
  logic [7:0]            b_plus2;
  logic [6:0]            off;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && !q_full && !burst_pending;
  assign accept    = in_valid && in_ready;

  assign oversize = (({5'd0, cfg_count, 1'b0} + 11'd5) > 11'(REPLY_BUFFER_BYTES))
                    || (cfg_count > 5'(STORE_DEPTH));
  assign total    = REPLY_OVERHEAD + {1'b0, run_count, 1'b0};
  assign b_plus2  = {1'b0, bytes_received} + 8'd2;
  assign off      = bytes_received - 7'd3;

  assign ram_waddr = off[5:1];
  assign ram_wdata = {held_high, rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slave   <= RST_SLAVE_ID;
      cfg_start   <= RST_START_REGISTER;
      cfg_count   <= RST_REGISTER_COUNT;
      cfg_timeout <= RST_TIMEOUT_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLAVE_ID:       cfg_slave   <= cfg_data[7:0];
        REG_START_REGISTER: cfg_start   <= cfg_data;
        REG_REGISTER_COUNT: cfg_count   <= cfg_data[WORD_IDX_W-1:0];
        REG_TIMEOUT_TICKS:  cfg_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    awaiting_next       = awaiting;
    bytes_received_next = bytes_received;
    elapsed_next        = elapsed;
    running_crc_next    = running_crc;
    header_bad_next     = header_bad;
    held_high_next      = held_high;
    crc_low_next        = crc_low;
    run_slave_next      = run_slave;
    run_count_next      = run_count;
    burst_pending_next  = burst_pending && !back_stat.burst_done;
    q_push              = 1'b0;
    q_cmd               = '0;
    ram_we              = 1'b0;

    if (accept) begin
      unique case (mode_t'(mode))
        MODE_START: begin
          q_push              = 1'b1;
          q_cmd.op            = CMD_REQUEST;
          q_cmd.slave         = cfg_slave;
          q_cmd.start         = cfg_start;
          q_cmd.count         = cfg_count;
          q_cmd.oversize      = oversize;
          q_cmd.code          = ST_BAD_HEADER;
          awaiting_next       = !oversize;
          bytes_received_next = '0;
          elapsed_next        = '0;
          running_crc_next    = CRC_INIT;
          header_bad_next     = 1'b0;
          held_high_next      = '0;
          crc_low_next        = '0;
          run_slave_next      = cfg_slave;
          run_count_next      = cfg_count;
        end
        MODE_BYTE: begin
          if (awaiting) begin
            if (b_plus2 < {1'b0, total}) begin
              running_crc_next = crc_feed(running_crc, rx_byte);
              if (bytes_received == 7'd0 && rx_byte != run_slave) begin
                header_bad_next = 1'b1;
              end
              if (bytes_received == 7'd1 && rx_byte != FUNC_READ_HOLDING) begin
                header_bad_next = 1'b1;
              end
              if (bytes_received == 7'd2 && rx_byte != {2'b00, run_count, 1'b0}) begin
                header_bad_next = 1'b1;
              end
              if (bytes_received >= 7'd3) begin
                if (!off[0]) begin
                  held_high_next = rx_byte;
                end else begin
                  ram_we = 1'b1;
                end
              end
              bytes_received_next = bytes_received + 7'd1;
            end else if (b_plus2 == {1'b0, total}) begin
              crc_low_next        = rx_byte;
              bytes_received_next = bytes_received + 7'd1;
            end else begin
              awaiting_next       = 1'b0;
              bytes_received_next = '0;
              q_push              = 1'b1;
              q_cmd.count         = run_count;
              if (header_bad) begin
                q_cmd.op   = CMD_STATUS;
                q_cmd.code = ST_BAD_HEADER;
              end else if ({rx_byte, crc_low} != running_crc) begin
                q_cmd.op   = CMD_STATUS;
                q_cmd.code = ST_CRC_BAD;
              end else begin
                q_cmd.op           = CMD_WORDS;
                q_cmd.code         = ST_OK;
                burst_pending_next = 1'b1;
              end
            end
          end
        end
        MODE_TICK: begin
          if (awaiting) begin
            elapsed_next = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
            if (elapsed_next >= cfg_timeout) begin
              awaiting_next       = 1'b0;
              bytes_received_next = '0;
              q_push              = 1'b1;
              q_cmd.op            = CMD_STATUS;
              q_cmd.code          = ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b0;
      bytes_received <= '0;
      elapsed        <= '0;
      running_crc    <= CRC_INIT;
      header_bad     <= 1'b0;
      held_high      <= '0;
      crc_low        <= '0;
      run_slave      <= RST_SLAVE_ID;
      run_count      <= RST_REGISTER_COUNT;
      burst_pending  <= 1'b0;
    end else begin
      awaiting       <= awaiting_next;
      bytes_received <= bytes_received_next;
      elapsed        <= elapsed_next;
      running_crc    <= running_crc_next;
      header_bad     <= header_bad_next;
      held_high      <= held_high_next;
      crc_low        <= crc_low_next;
      run_slave      <= run_slave_next;
      run_count      <= run_count_next;
      burst_pending  <= burst_pending_next;
    end
  end

endmodule

FILE: hw/rtl/mrhm_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on mrhm_pkg.
module mrhm_queue import mrhm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign pop_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

FILE: hw/rtl/mrhm_back.sv
// Back part: takes commands from the queue and emits request bytes,
// register words from the word store, and status results. Depends on mrhm_pkg.
module mrhm_back import mrhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output back_stat_t            back_stat,
  output logic                  ram_re,
  output logic [WORD_IDX_W-1:0] ram_raddr,
  input  logic [15:0]           ram_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [15:0]           data,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic [1:0]            status,
  output logic                  last
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_REQ  = 5'b00010,
    B_READ = 5'b00100,
    B_WORD = 5'b01000,
    B_STAT = 5'b10000
  } back_state_t;

  back_state_t           state, state_next;
  cmd_t                  cur, cur_next;
  logic [2:0]            req_idx, req_idx_next;
  logic [15:0]           crc, crc_next;
  logic [WORD_IDX_W-1:0] widx, widx_next;
  status_t               code, code_next;

  logic                  o_valid, o_valid_next;
  kind_t                 o_kind, o_kind_next;
  logic [15:0]           o_data, o_data_next;
  logic [WORD_IDX_W-1:0] o_index, o_index_next;
  status_t               o_status, o_status_next;
  logic                  o_last, o_last_next;

  logic                  out_free;
  logic [7:0]            req_byte;

  assign out_free  = !o_valid || out_ready;
  assign ram_raddr = widx;

  always_comb begin
    unique case (req_idx)
      3'd0: req_byte = cur.slave;
      3'd1: req_byte = FUNC_READ_HOLDING;
      3'd2: req_byte = cur.start[15:8];
      3'd3: req_byte = cur.start[7:0];
      3'd4: req_byte = 8'h00;
      3'd5: req_byte = {3'b000, cur.count};
      3'd6: req_byte = crc[7:0];
      3'd7: req_byte = crc[15:8];
      default: req_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    req_idx_next  = req_idx;
    crc_next      = crc;
    widx_next     = widx;
    code_next     = code;
    o_valid_next  = o_valid && !out_ready;
    o_kind_next   = o_kind;
    o_data_next   = o_data;
    o_index_next  = o_index;
    o_status_next = o_status;
    o_last_next   = o_last;
    q_pop         = 1'b0;
    ram_re        = 1'b0;
    back_stat     = '0;

    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_next  = q_cmd;
          code_next = q_cmd.code;
          widx_next = '0;
          unique case (q_cmd.op)
            CMD_REQUEST: begin
              req_idx_next = '0;
              crc_next     = CRC_INIT;
              state_next   = B_REQ;
            end
            CMD_WORDS: begin
              if (q_cmd.count == '0) begin
                back_stat.burst_done = 1'b1;
                state_next           = B_STAT;
              end else begin
                state_next = B_READ;
              end
            end
            default: state_next = B_STAT;
          endcase
        end
      end
      B_REQ: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = KIND_REQUEST;
          o_data_next   = {8'h00, req_byte};
          o_index_next  = '0;
          o_status_next = ST_OK;
          o_last_next   = (req_idx == 3'd7) && !cur.oversize;
          if (req_idx < 3'd6) begin
            crc_next = crc_feed(crc, req_byte);
          end
          req_idx_next = req_idx + 3'd1;
          if (req_idx == 3'd7) begin
            state_next = cur.oversize ? B_STAT : B_IDLE;
          end
        end
      end
      B_READ: begin
        ram_re     = 1'b1;
        state_next = B_WORD;
      end
      B_WORD: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = KIND_WORD;
          o_data_next   = ram_rdata;
          o_index_next  = widx;
          o_status_next = ST_OK;
          o_last_next   = 1'b0;
          if (widx == cur.count - 5'd1) begin
            back_stat.burst_done = 1'b1;
            state_next           = B_STAT;
          end else begin
            widx_next  = widx + 5'd1;
            state_next = B_READ;
          end
        end
      end
      B_STAT: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = KIND_STATUS;
          o_data_next   = '0;
          o_index_next  = '0;
          o_status_next = code;
          o_last_next   = 1'b1;
          state_next    = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    req_idx  <= req_idx_next;
    crc      <= crc_next;
    widx     <= widx_next;
    code     <= code_next;
    o_kind   <= o_kind_next;
    o_data   <= o_data_next;
    o_index  <= o_index_next;
    o_status <= o_status_next;
    o_last   <= o_last_next;
  end

  assign out_valid  = o_valid;
  assign kind       = o_kind;
  assign data       = o_data;
  assign word_index = o_index;
  assign status     = o_status;
  assign last       = o_last;

endmodule

FILE: hw/rtl/modbus_rtu_read_holding_master.sv
// Top level of the Modbus RTU read-holding-registers master.
// Depends on mrhm_pkg, mrhm_ram, mrhm_front, mrhm_queue and mrhm_back.
//
// Input channel (in_valid/in_ready, mode, rx_byte): a start item sends a request,
// a byte item carries one received reply byte, a tick item advances the timeout.
// Output channel (out_valid/out_ready): request bytes, register words and status;
// last marks the final result caused by one input item.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is ready outside reset.
// The front takes one input item per cycle while the two-entry command queue has
// room and no word burst is pending; parsing, CRC and timeout are done in that cycle.
// The back drains the queue: the eight request bytes go out one per cycle while the
// output is not stalled, a status leaves through the B_STAT state, and each register
// word passes through B_READ and B_WORD for the registered store read. Input is held
// off from a good reply's final byte until the last word reaches the output register.
// A stalled receiver holds the output register; the queue then fills and input
// stalls. Reset clears the control state and loads the register defaults
// (slave 1, start 0, count 8, timeout 1000); the word store is not cleared.
module modbus_rtu_read_holding_master import mrhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [15:0]           data,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic [1:0]            status,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  logic                  q_push, q_full, q_pop, q_empty;
  cmd_t                  q_in, q_out;
  back_stat_t            back_stat;
  logic                  ram_we, ram_re;
  logic [WORD_IDX_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]           ram_wdata, ram_rdata;

  mrhm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full),
    .back_stat (back_stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  mrhm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .empty    (q_empty)
  );

  mrhm_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrhm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (q_out),
    .q_pop      (q_pop),
    .back_stat  (back_stat),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data       (data),
    .word_index (word_index),
    .status     (status),
    .last       (last)
  );

endmodule
